>>> design/mcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

    localparam int NUM_EDGES  = 12;
    localparam int MAX_VERTS  = 15;
    localparam int FRAC_W     = 9;
    localparam int COORD_W    = 14;
    localparam int VAL_W      = 16;
    localparam int CELL_W     = 5;
    localparam int DIV_STEPS  = 9;
    localparam logic [VAL_W-1:0] ISO_RESET = 16'd32640;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

    typedef logic [8*MAX_VERTS-1:0] t_tri_str;
    typedef logic [FRAC_W-1:0] t_frac;

    typedef struct packed {
        logic [FRAC_W-1:0] x;
        logic [FRAC_W-1:0] y;
        logic [FRAC_W-1:0] z;
    } t_pos;

    // Everything the emitter needs for one cube, handed over in a single transfer.
    typedef struct packed {
        t_tri_str           tri_str;
        logic [3:0]         n_verts;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COORD_W-1:0] base_z;
        t_frac [NUM_EDGES-1:0] frac;
    } t_cube_res;

    // Corner offsets packed as {x, y, z}.
    localparam logic [2:0] CORNER_OFF [8] = '{
        3'b000, 3'b100, 3'b101, 3'b001, 3'b010, 3'b110, 3'b111, 3'b011
    };
    localparam logic [2:0] EDGE_A [NUM_EDGES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3
    };
    localparam logic [2:0] EDGE_B [NUM_EDGES] = '{
        3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7
    };

    // Standard triangle table; one ASCII hex digit per edge, right-justified.
    localparam t_tri_str TRI_ROM [256] = '{
"","083","019","183981","12a","08312a","92a029","2832a8a98",
"3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
"478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
"8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4","47890b9bab03",
"47b4b99ba",
"954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
"95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba","54050b5bab03",
"54858aa8b",
"978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
"2a5253357",
"7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b","5705097b010aba0",
"ba0b03a50807570","ba57b5",
"a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
"23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6","3b6036065059",
"65969bb98",
"5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347","847905065026",
"739794329596269",
"3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6","51b5b610b7b404b",
"059065036b63847","65969b4797b9",
"a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
"832824426",
"a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63","8b1810b61914641",
"3b6360064","648b68",
"7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867","269291679093739",
"780706602","732672",
"23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136","091b67",
"7807063b0b60","7b6",
"76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
"723627","708760620","276237019","162186198876","a76a17137","a7617a187108","03707a0a96a7",
"76a7a88a9",
"684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046","4b846b0292a9",
"a93a32943b36463",
"823842462","042462","190234246438","194142246","8138618466a1","a10a06604","4634386a3039a93",
"a946a4",
"49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495","76b54a42a402",
"348354325a52b76",
"723762549","954086062687","362376150540","628687218485158","954a16176137","16a176107870954",
"40a4a503a6a737a","76a7a854a48a",
"6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56","0b306b09656912a",
"b85b56805a52025","6b36352a3a53",
"589528562382","956960062","158180568382628","156216","13616a386569896","a10a06950560",
"03856a","a56",
"b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b17751","08312717572b","9759279022b7",
"75272b592328982",
"25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175","903935537",
"987597",
"5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458","04b0b345b2b151b",
"0250592b5458b85","9452b3",
"25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
"845853905035","945",
"4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912","9749b791b2b1083",
"b74b42240","b74b42834324",
"29a279237749","9a79742a7870207","37a3a274a1a040a","1a2874","491417713","491417081871",
"403743","487",
"9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
"23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
    };

    // Number of digits held in a table entry.
    function automatic logic [3:0] tri_len(input t_tri_str s);
        logic [3:0] cnt;
        cnt = '0;
        for (int j = 0; j < MAX_VERTS; j++) begin
            if (s[8*j +: 8] != 8'd0) cnt = cnt + 4'd1;
        end
        return cnt;
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    // Offset of the vertex on an edge within the cube, per axis.
    function automatic logic [FRAC_W-1:0] axis_pos(input logic p1, input logic p2,
                                                   input t_frac frac);
        if (p1 == p2) return p1 ? FRAC_ONE : '0;
        else if (p2) return frac;
        else return FRAC_ONE - frac;
    endfunction

    function automatic t_pos edge_pos(input logic [3:0] e, input t_frac frac);
        logic [2:0] ca;
        logic [2:0] cb;
        t_pos p;
        ca = CORNER_OFF[EDGE_A[e]];
        cb = CORNER_OFF[EDGE_B[e]];
        p.x = axis_pos(ca[2], cb[2], frac);
        p.y = axis_pos(ca[1], cb[1], frac);
        p.z = axis_pos(ca[0], cb[0], frac);
        return p;
    endfunction

endpackage
`default_nettype wire

>>> design/mcc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mcc_cube_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [4:0]  cell_z;
    logic [15:0] corner_value_0;
    logic [15:0] corner_value_1;
    logic [15:0] corner_value_2;
    logic [15:0] corner_value_3;
    logic [15:0] corner_value_4;
    logic [15:0] corner_value_5;
    logic [15:0] corner_value_6;
    logic [15:0] corner_value_7;
    modport source (output valid, cell_x, cell_y, cell_z, corner_value_0, corner_value_1,
                    corner_value_2, corner_value_3, corner_value_4, corner_value_5,
                    corner_value_6, corner_value_7, input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, corner_value_0, corner_value_1,
                  corner_value_2, corner_value_3, corner_value_4, corner_value_5,
                  corner_value_6, corner_value_7, output ready);
endinterface

interface mcc_vert_if;
    logic        valid;
    logic        ready;
    logic [13:0] vertex_x;
    logic [13:0] vertex_y;
    logic [13:0] vertex_z;
    logic        last_vertex;
    modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface mcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] iso_level;
    modport source (output valid, iso_level, input ready);
    modport sink (input valid, iso_level, output ready);
endinterface
`default_nettype wire

>>> design/mcc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module mcc_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_load,
    input  wire logic                      i_step,
    input  wire logic [mcc_pkg::VAL_W-1:0] i_v1,
    input  wire logic [mcc_pkg::VAL_W-1:0] i_v2,
    input  wire logic [mcc_pkg::VAL_W-1:0] i_iso,
    output mcc_pkg::t_frac                 o_frac
);
    import mcc_pkg::*;

    logic [VAL_W-1:0]  den;
    logic [VAL_W-1:0]  num;
    logic [25:0]       dividend;
    logic [16:0]       divisor;
    logic [25:0]       r_rem;
    logic [24:0]       r_dsh;
    logic [8:0]        r_q;
    logic              r_sat;
    logic              r_eq;
    logic              take;

    always_comb begin
        den      = (i_v1 > i_v2) ? (i_v1 - i_v2) : (i_v2 - i_v1);
        num      = (i_iso > i_v1) ? (i_iso - i_v1) : (i_v1 - i_iso);
        dividend = {1'b0, num, 9'b0} + {10'b0, den};
        divisor  = {den, 1'b0};
        take     = ({1'b0, r_dsh} <= r_rem);
    end

    // Restoring division, one quotient bit per step, most significant first.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eq  <= (i_v1 == i_v2);
            r_sat <= (dividend >= {divisor, 9'b0});
            r_rem <= dividend;
            r_dsh <= {divisor, 8'b0};
            r_q   <= '0;
        end else if (i_step) begin
            if (take) r_rem <= r_rem - {1'b0, r_dsh};
            r_dsh <= {1'b0, r_dsh[24:1]};
            r_q   <= {r_q[7:0], take};
        end
    end

    assign o_frac = r_eq ? '0 : ((r_sat || (r_q > FRAC_ONE)) ? FRAC_ONE : r_q);
endmodule
`default_nettype wire

>>> design/mcc_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module mcc_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  mcc_pkg::t_cube_res  i_res,
    output logic                o_free,
    mcc_vert_if.source          o_vert
);
    import mcc_pkg::*;

    t_cube_res   r_res;
    logic        r_busy;
    logic [3:0]  r_i;
    logic [3:0]  r_t3;
    logic [1:0]  r_r;
    logic        r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic        r_last;

    logic        adv;
    logic        last;
    logic [3:0]  src;
    logic [3:0]  bi;
    logic [3:0]  edge_raw;
    logic [3:0]  edge_idx;
    t_pos        pos;

    always_comb begin
        adv      = !r_valid || o_vert.ready;
        last     = (r_i + 4'd1 == r_res.n_verts);
        // Winding is reversed: the third vertex of each triangle goes first.
        src      = r_t3 + 4'd2 - {2'b0, r_r};
        bi       = r_res.n_verts - 4'd1 - src;
        edge_raw = hex_digit(r_res.tri_str[{bi, 3'b000} +: 8]);
        edge_idx = (edge_raw > 4'd11) ? (edge_raw - 4'd12) : edge_raw;
        pos      = edge_pos(edge_idx, r_res.frac[edge_idx]);
        o_free   = !r_busy || (adv && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (adv) r_valid <= r_busy;
            if (adv && r_busy) begin
                r_x    <= r_res.base_x + {5'b0, pos.x};
                r_y    <= r_res.base_y + {5'b0, pos.y};
                r_z    <= r_res.base_z + {5'b0, pos.z};
                r_last <= last;
                r_i    <= r_i + 4'd1;
                if (r_r == 2'd2) begin
                    r_r  <= 2'd0;
                    r_t3 <= r_t3 + 4'd3;
                end else begin
                    r_r <= r_r + 2'd1;
                end
                if (last) r_busy <= 1'b0;
            end
            if (i_load) begin
                r_res  <= i_res;
                r_busy <= (i_res.n_verts != 4'd0);
                r_i    <= '0;
                r_r    <= '0;
                r_t3   <= '0;
            end
        end
    end

    assign o_vert.valid       = r_valid;
    assign o_vert.vertex_x    = r_x;
    assign o_vert.vertex_y    = r_y;
    assign o_vert.vertex_z    = r_z;
    assign o_vert.last_vertex = r_last;
endmodule
`default_nettype wire

>>> design/marching_cubes_cell.sv
// Flow: a cube is taken when the edge lanes are free; its edge divisions, one per edge, run
// bit-serially in lockstep lanes, then the result passes to the emitter once it is free,
// which sends one vertex per cycle through the single output port while not stalled.
// The lanes take a new cube once the last is handed over, overlapping its output.
// Reset: synchronous, active low; clears the handshake state and loads iso_level 32640.
`timescale 1ns / 1ps
`default_nettype none
module marching_cubes_cell #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcc_cube_if.sink  i_cube,
    mcc_cfg_if.sink   i_cfg,
    mcc_vert_if.source o_vert
);
    import mcc_pkg::*;

    localparam logic [8:0] CELL_MAX = 9'(GRID_SIZE - 1);

    logic [VAL_W-1:0] r_iso;
    logic             r_lbusy;
    logic [3:0]       r_lcnt;
    t_tri_str         r_str;
    logic [3:0]       r_n;
    logic [COORD_W-1:0] r_bx;
    logic [COORD_W-1:0] r_by;
    logic [COORD_W-1:0] r_bz;

    logic [VAL_W-1:0] corner [8];
    logic [7:0]       case_idx;
    logic             accept;
    logic             lanes_done;
    logic             emit_free;
    logic             handoff;
    t_frac [NUM_EDGES-1:0] frac;
    t_cube_res        res;
    t_tri_str         str_sel;

    // A cell index beyond the grid is held at its last cell.
    function automatic logic [COORD_W-1:0] cell_base(input logic [CELL_W-1:0] c);
        logic [8:0] s;
        s = ({4'b0, c} > CELL_MAX) ? CELL_MAX : {4'b0, c};
        return COORD_W'({s, 8'b0});
    endfunction

    always_comb begin
        corner[0] = i_cube.corner_value_0;
        corner[1] = i_cube.corner_value_1;
        corner[2] = i_cube.corner_value_2;
        corner[3] = i_cube.corner_value_3;
        corner[4] = i_cube.corner_value_4;
        corner[5] = i_cube.corner_value_5;
        corner[6] = i_cube.corner_value_6;
        corner[7] = i_cube.corner_value_7;
        // A corner below the surface level sets its bit of the case index.
        for (int k = 0; k < 8; k++) case_idx[k] = (corner[k] < r_iso);
        str_sel = TRI_ROM[case_idx];
    end

    // The configuration register is always ready; writes must come only while idle; the block does not enforce this.
    assign i_cfg.ready  = 1'b1;
    assign i_cube.ready = !r_lbusy;
    assign accept       = i_cube.valid && !r_lbusy;
    assign lanes_done   = (r_lcnt == 4'(DIV_STEPS));
    assign handoff      = r_lbusy && lanes_done && emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso   <= ISO_RESET;
            r_lbusy <= 1'b0;
            r_lcnt  <= '0;
        end else begin
            if (i_cfg.valid) r_iso <= i_cfg.iso_level;
            if (accept) begin
                r_lbusy <= 1'b1;
                r_lcnt  <= '0;
                r_str   <= str_sel;
                r_n     <= tri_len(str_sel);
                r_bx    <= cell_base(i_cube.cell_x);
                r_by    <= cell_base(i_cube.cell_y);
                r_bz    <= cell_base(i_cube.cell_z);
            end else if (r_lbusy) begin
                if (!lanes_done) r_lcnt <= r_lcnt + 4'd1;
                else if (emit_free) r_lbusy <= 1'b0;
            end
        end
    end

    // One interpolation lane per cube edge; all twelve run in lockstep.
    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
        mcc_lane u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_step (r_lbusy && !lanes_done),
            .i_v1   (corner[EDGE_A[e]]),
            .i_v2   (corner[EDGE_B[e]]),
            .i_iso  (r_iso),
            .o_frac (frac[e])
        );
    end

    always_comb begin
        res.tri_str = r_str;
        res.n_verts = r_n;
        res.base_x  = r_bx;
        res.base_y  = r_by;
        res.base_z  = r_bz;
        res.frac    = frac;
    end

    // The merging stage picks each listed edge's lane result and sends the vertices out.
    mcc_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (handoff),
        .i_res   (res),
        .o_free  (emit_free),
        .o_vert  (o_vert)
    );
endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import mcc_pkg::*;

    // Surface vertex as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } t_vert;

    // Corner offsets {x, y, z} and edge end corners, held locally for prediction.
    localparam logic [2:0] CORN [8] = '{
        3'b000, 3'b100, 3'b101, 3'b001, 3'b010, 3'b110, 3'b111, 3'b011
    };
    localparam int END_A [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
    localparam int END_B [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   fail_count;
    int   vert_count;
    int   cube_count;
    bit   drain_busy;

    mcc_cube_if cube_ch ();
    mcc_cfg_if  cfg_ch ();
    mcc_vert_if vert_ch ();

    marching_cubes_cell #(.GRID_SIZE(32)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cube (cube_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_vert (vert_ch.source)
    );

    logic [15:0] iso_now;
    t_vert       pending_verts[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap lengths: mostly zero or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Rounded crossing fraction along one edge, in 1/256 cube.
    function automatic logic [8:0] crossing_frac(logic [15:0] v1, logic [15:0] v2);
        longint unsigned den, num, q;
        if (v1 == v2) return 9'd0;
        den = (v1 > v2) ? v1 - v2 : v2 - v1;
        num = (iso_now > v1) ? iso_now - v1 : v1 - iso_now;
        q = (num * 512 + den) / (den * 2);
        return (q > 256) ? 9'd256 : q[8:0];
    endfunction

    // Work out the triangle vertices of one cube, winding reversed, into the queue.
    task automatic predict_cube(logic [4:0] cx, logic [4:0] cy, logic [4:0] cz,
                                logic [15:0] val [8]);
        logic [7:0]  case_idx;
        t_tri_str    row;
        int          n, src, e, a, b;
        logic [8:0]  frac;
        logic [13:0] base [3];
        logic [13:0] off [3];
        logic        pa, pb;
        t_vert       v;
        case_idx = '0;
        for (int k = 0; k < 8; k++) if (val[k] < iso_now) case_idx[k] = 1'b1;
        row = TRI_ROM[case_idx];
        n = 0;
        for (int j = 0; j < MAX_VERTS; j++) if (row[8*j +: 8] != 8'd0) n++;
        n -= n % 3;
        base[0] = {1'b0, cx, 8'd0};
        base[1] = {1'b0, cy, 8'd0};
        base[2] = {1'b0, cz, 8'd0};
        for (int i = 0; i < n; i++) begin
            src = (i / 3) * 3 + 2 - (i % 3);
            // Strings are right-justified: digit src counts from the most significant.
            e = row[8*(n - 1 - src) +: 8];
            e = (e >= "a") ? e - "a" + 10 : e - "0";
            a = END_A[e];
            b = END_B[e];
            frac = crossing_frac(val[a], val[b]);
            for (int k = 0; k < 3; k++) begin
                pa = CORN[a][2 - k];
                pb = CORN[b][2 - k];
                if (pa == pb) off[k] = pa ? 14'd256 : 14'd0;
                else if (pb) off[k] = 14'(frac);
                else off[k] = 14'd256 - 14'(frac);
            end
            v.x = base[0] + off[0];
            v.y = base[1] + off[1];
            v.z = base[2] + off[2];
            v.last = (i + 1 == n);
            pending_verts.push_back(v);
        end
    endtask

    // Send one cube and record what it should produce. Valid stays high after the
    // transfer so that a following cube can be presented without a gap.
    task automatic send_cube(logic [4:0] cx, logic [4:0] cy, logic [4:0] cz,
                             logic [15:0] val [8]);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            cube_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cube_ch.cell_x <= cx;
        cube_ch.cell_y <= cy;
        cube_ch.cell_z <= cz;
        cube_ch.corner_value_0 <= val[0];
        cube_ch.corner_value_1 <= val[1];
        cube_ch.corner_value_2 <= val[2];
        cube_ch.corner_value_3 <= val[3];
        cube_ch.corner_value_4 <= val[4];
        cube_ch.corner_value_5 <= val[5];
        cube_ch.corner_value_6 <= val[6];
        cube_ch.corner_value_7 <= val[7];
        cube_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cube_ch.ready) @(posedge i_clk);
        predict_cube(cx, cy, cz, val);
        cube_count++;
        @(negedge i_clk);
    endtask

    // Wait until every vertex has come out, then let the pipeline settle.
    task automatic wait_drained();
        cube_ch.valid <= 1'b0;
        while (pending_verts.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_iso(logic [15:0] lvl);
        wait_drained();
        cfg_ch.iso_level <= lvl;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        iso_now = lvl;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // A random cube: values are mostly spread near the threshold so that many edges are crossed.
    task automatic send_random_cube();
        logic [15:0] val [8];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 8; k++) begin
            if (mode < 6) val[k] = 16'(iso_now + $urandom_range(0, 1023) - 512);
            else if (mode < 8) val[k] = 16'($urandom);
            else val[k] = ($urandom_range(0, 1)) ? iso_now : iso_now - 16'd1;
        end
        send_cube(5'($urandom), 5'($urandom), 5'($urandom), val);
    endtask

    // Extreme corner values and cases: empty, full, single corner, alternating, equal edge values, ambiguous.
    task automatic test_directed();
        logic [15:0] val [8];
        for (int k = 0; k < 8; k++) val[k] = 16'hFFFF;
        send_cube(5'd0, 5'd0, 5'd0, val);
        for (int k = 0; k < 8; k++) val[k] = 16'h0000;
        send_cube(5'd31, 5'd31, 5'd31, val);
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 8; k++) val[k] = 16'hFFFF;
            val[c] = 16'h0000;
            send_cube(5'd31, 5'd0, 5'd17, val);
        end
        for (int k = 0; k < 8; k++) val[k] = k[0] ? 16'hFFFF : 16'h0000;
        send_cube(5'd10, 5'd21, 5'd5, val);
        for (int k = 0; k < 8; k++) val[k] = iso_now;
        val[0] = iso_now - 16'd1;
        send_cube(5'd31, 5'd31, 5'd0, val);
        // Ambiguous case with four triangles.
        val = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        send_cube(5'd1, 5'd2, 5'd3, val);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_random_cube();
    endtask

    // After every fifth cube, the sender holds off until the block has delivered everything outstanding.
    task automatic test_hold_off();
        for (int i = 0; i < 20; i++) begin
            send_random_cube();
            if (i % 5 == 4) wait_drained();
        end
    endtask

    // Receiver: random stalls on ready, checks every vertex in order.
    initial begin
        int gap;
        vert_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (drain_busy || $urandom_range(0, 3) != 0) vert_ch.ready <= 1'b1;
            else begin
                gap = pick_gap();
                if (gap == 0) vert_ch.ready <= 1'b1;
                else begin
                    vert_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    vert_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_vert want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && vert_ch.valid && vert_ch.ready) begin
            vert_count++;
            if (pending_verts.size() == 0) begin
                $error("vertex with nothing expected: %0d %0d %0d", vert_ch.vertex_x,
                       vert_ch.vertex_y, vert_ch.vertex_z);
                fail_count++;
            end else begin
                want = pending_verts.pop_front();
                if (vert_ch.vertex_x !== want.x) begin
                    $error("vertex_x expected %0d actual %0d", want.x, vert_ch.vertex_x);
                    fail_count++;
                end
                if (vert_ch.vertex_y !== want.y) begin
                    $error("vertex_y expected %0d actual %0d", want.y, vert_ch.vertex_y);
                    fail_count++;
                end
                if (vert_ch.vertex_z !== want.z) begin
                    $error("vertex_z expected %0d actual %0d", want.z, vert_ch.vertex_z);
                    fail_count++;
                end
                if (vert_ch.last_vertex !== want.last) begin
                    $error("last_vertex expected %0d actual %0d", want.last,
                           vert_ch.last_vertex);
                    fail_count++;
                end
            end
        end
        if (cycle_count > 2000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        fail_count = 0;
        vert_count = 0;
        cube_count = 0;
        drain_busy = 1'b0;
        iso_now = ISO_RESET;
        i_rst_n = 1'b0;
        cube_ch.valid = 1'b0;
        cube_ch.cell_x = '0;
        cube_ch.cell_y = '0;
        cube_ch.cell_z = '0;
        cube_ch.corner_value_0 = '0;
        cube_ch.corner_value_1 = '0;
        cube_ch.corner_value_2 = '0;
        cube_ch.corner_value_3 = '0;
        cube_ch.corner_value_4 = '0;
        cube_ch.corner_value_5 = '0;
        cube_ch.corner_value_6 = '0;
        cube_ch.corner_value_7 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.iso_level = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(120);
        write_iso(16'h0000);
        test_random(30);
        write_iso(16'hFFFF);
        test_directed();
        test_random(30);
        write_iso(16'h0001);
        test_random(40);
        write_iso(16'($urandom));
        test_hold_off();
        test_random(100);
        write_iso(16'd32640);
        test_random(90);

        wait_drained();
        drain_busy = 1'b1;
        repeat (30) @(negedge i_clk);
        $display("Covered %0d cubes and %0d vertices over five iso levels,", cube_count,
                 vert_count);
        $display("including empty, full, single-corner and ambiguous cases.");
        if (fail_count == 0 && pending_verts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
design/mcc_pkg.sv
design/mcc_if.sv
design/mcc_lane.sv
design/mcc_emit.sv
design/marching_cubes_cell.sv
sim/tb.sv
